/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the strict-priority three-class queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned NumClasses = 3;

  typedef enum logic {
    OpEnqueue = 1'b0,
    OpServe   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ClassNormal   = 2'd0,
    ClassPriority = 2'd1,
    ClassUrgent   = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    StEnqueued = 2'd0,
    StServed   = 2'd1,
    StEmpty    = 2'd2,
    StDropped  = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] patient;
    logic [15:0] ticket;
    logic [7:0]  age;
  } entry_t;

  // per-cycle commands from a ring to its cells
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // per-cycle commands from the top level to one ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  // ring status back to the top level
  typedef struct packed {
    logic nonempty;
    logic full;
  } ring_stat_t;

endpackage

/* hw/rtl/spq_if.sv */
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  queue_class;
  logic [15:0] patient_id;
  logic [15:0] ticket_id;
  logic [7:0]  patient_age;

  modport source (
    output valid, op, queue_class, patient_id, ticket_id, patient_age,
    input  ready
  );
  modport sink (
    input  valid, op, queue_class, patient_id, ticket_id, patient_age,
    output ready
  );
endinterface

interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  served_class;
  logic [15:0] served_patient;
  logic [15:0] served_ticket;
  logic [7:0]  served_age;

  modport source (
    output valid, status, served_class, served_patient, served_ticket, served_age,
    input  ready
  );
  modport sink (
    input  valid, status, served_class, served_patient, served_ticket, served_age,
    output ready
  );
endinterface

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of a shifting FIFO ring: holds an entry and its occupied flag,
// takes a new entry when it is the first free slot, shifts toward the head.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     entry_i,
  input  logic                prev_valid_i,
  input  logic                next_valid_i,
  input  spq_pkg::entry_t     next_entry_i,
  output logic                valid_o,
  output spq_pkg::entry_t     entry_o
);

  logic            valid_q, valid_d;
  spq_pkg::entry_t entry_q, entry_d;
  logic            take;

  assign take = ctrl_i.push && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (take) begin
      valid_d = 1'b1;
      entry_d = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

/* hw/rtl/spq_ring.sv */
// ----------------------------------------------------------------------------
// spq_ring
// Bounded FIFO of one class built as a row of cells; cell 0 is the head.
// ----------------------------------------------------------------------------
module spq_ring #(
  parameter int unsigned Depth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::ring_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     entry_i,
  output spq_pkg::ring_stat_t stat_o,
  output spq_pkg::entry_t     head_o
);

  logic [Depth-1:0]    valid;
  spq_pkg::entry_t     entry [Depth];
  spq_pkg::cell_ctrl_t cell_ctrl;

  assign cell_ctrl.push = ctrl_i.push;
  assign cell_ctrl.pop  = ctrl_i.pop;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic            prev_valid;
    logic            next_valid;
    spq_pkg::entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = valid[i+1];
      assign next_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .entry_i      (entry_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .valid_o      (valid[i]),
      .entry_o      (entry[i])
    );
  end

  assign stat_o.nonempty = valid[0];
  assign stat_o.full     = valid[Depth-1];
  assign head_o          = entry[0];

endmodule

/* hw/rtl/strict_priority_three_queue.sv */
// ----------------------------------------------------------------------------
// strict_priority_three_queue
// Three bounded FIFO rings (normal, priority, urgent) with strict-priority
// serve: urgent first, then priority, then normal.
//
//   channel  dir  payload
//   req_i    in   op, queue_class, patient_id, ticket_id, patient_age
//   rsp_o    out  status, served_class, served_patient, served_ticket,
//                 served_age
//
// One request per cycle while rsp_o does not stall; each request gives one result,
// registered and shown in the cycle after it is accepted. The cell rows never hold a request back.
// Reset clears the occupied flags of all cells and the result valid flag.
// A result waiting on rsp_o holds req_i ready low only if rsp_o stalls.
// ----------------------------------------------------------------------------
module strict_priority_three_queue #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  localparam int unsigned NumClasses = spq_pkg::NumClasses;

  spq_pkg::ring_ctrl_t ring_ctrl [NumClasses];
  spq_pkg::ring_stat_t ring_stat [NumClasses];
  spq_pkg::entry_t     ring_head [NumClasses];
  spq_pkg::entry_t     req_entry;

  logic                 accept;
  logic                 is_enq;
  logic                 is_serve;
  logic [NumClasses-1:0] push_ok;
  logic [NumClasses-1:0] pop_sel;
  spq_pkg::class_e      sel_class;
  logic                 any_nonempty;
  spq_pkg::entry_t      sel_entry;

  logic                 out_valid_q;
  spq_pkg::status_e     status_q, status_d;
  logic [1:0]           class_q, class_d;
  spq_pkg::entry_t      served_q, served_d;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_enq      = accept && (req_i.op == spq_pkg::OpEnqueue);
  assign is_serve    = accept && (req_i.op == spq_pkg::OpServe);

  assign req_entry.patient = req_i.patient_id;
  assign req_entry.ticket  = req_i.ticket_id;
  assign req_entry.age     = req_i.patient_age;

  always_comb begin
    any_nonempty = 1'b1;
    if (ring_stat[spq_pkg::ClassUrgent].nonempty) begin
      sel_class = spq_pkg::ClassUrgent;
    end else if (ring_stat[spq_pkg::ClassPriority].nonempty) begin
      sel_class = spq_pkg::ClassPriority;
    end else begin
      sel_class    = spq_pkg::ClassNormal;
      any_nonempty = ring_stat[spq_pkg::ClassNormal].nonempty;
    end
  end

  always_comb begin
    case (sel_class)
      spq_pkg::ClassUrgent:   sel_entry = ring_head[spq_pkg::ClassUrgent];
      spq_pkg::ClassPriority: sel_entry = ring_head[spq_pkg::ClassPriority];
      default:                sel_entry = ring_head[spq_pkg::ClassNormal];
    endcase
  end

  for (genvar c = 0; c < NumClasses; c++) begin : g_ring
    assign push_ok[c] = (req_i.queue_class == 2'(c)) && !ring_stat[c].full;
    assign pop_sel[c] = any_nonempty && (sel_class == spq_pkg::class_e'(2'(c)));

    assign ring_ctrl[c].push = is_enq && push_ok[c];
    assign ring_ctrl[c].pop  = is_serve && pop_sel[c];

    spq_ring #(
      .Depth (QueueDepth)
    ) u_ring (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ring_ctrl[c]),
      .entry_i (req_entry),
      .stat_o  (ring_stat[c]),
      .head_o  (ring_head[c])
    );
  end

  always_comb begin
    status_d = status_q;
    class_d  = class_q;
    served_d = served_q;
    if (accept) begin
      class_d  = '0;
      served_d = '0;
      if (req_i.op == spq_pkg::OpEnqueue) begin
        status_d = (|push_ok) ? spq_pkg::StEnqueued : spq_pkg::StDropped;
      end else if (any_nonempty) begin
        status_d = spq_pkg::StServed;
        class_d  = sel_class;
        served_d = sel_entry;
      end else begin
        status_d = spq_pkg::StEmpty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    class_q  <= class_d;
    served_q <= served_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.served_class   = class_q;
  assign rsp_o.served_patient = served_q.patient;
  assign rsp_o.served_ticket  = served_q.ticket;
  assign rsp_o.served_age     = served_q.age;

endmodule

/* tb/strict_priority_three_queue_checker.sv */
// ----------------------------------------------------------------------------
// strict_priority_three_queue_checker
// Watches the request and result channels of the three-class queue, keeps
// its own copy of the three rings and compares every result transfer field
// by field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module strict_priority_three_queue_checker #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic        req_op_i,
  input  logic [1:0]  req_class_i,
  input  logic [15:0] req_patient_i,
  input  logic [15:0] req_ticket_i,
  input  logic [7:0]  req_age_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [1:0]  rsp_status_i,
  input  logic [1:0]  rsp_class_i,
  input  logic [15:0] rsp_patient_i,
  input  logic [15:0] rsp_ticket_i,
  input  logic [7:0]  rsp_age_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    spq_pkg::status_e status;
    spq_pkg::class_e  cls;
    logic [15:0]      patient;
    logic [15:0]      ticket;
    logic [7:0]       age;
  } outcome_t;

  spq_pkg::entry_t waiting_q [spq_pkg::NumClasses][$];
  outcome_t        outcome_q [$];
  int unsigned     mismatches = 0;

  function automatic outcome_t predict_outcome(logic op, logic [1:0] cls,
                                               spq_pkg::entry_t item);
    outcome_t        res;
    spq_pkg::entry_t head;
    res = '{status: spq_pkg::StEnqueued, cls: spq_pkg::ClassNormal,
            patient: '0, ticket: '0, age: '0};
    if (op == spq_pkg::OpEnqueue) begin
      if (cls >= spq_pkg::NumClasses || waiting_q[cls].size() >= QueueDepth) begin
        res.status = spq_pkg::StDropped;
      end else begin
        waiting_q[cls].push_back(item);
      end
    end else begin
      res.status = spq_pkg::StEmpty;
      // urgent first, then priority, then normal
      for (int c = spq_pkg::NumClasses - 1; c >= 0; c--) begin
        if (res.status == spq_pkg::StEmpty && waiting_q[c].size() != 0) begin
          head        = waiting_q[c].pop_front();
          res.status  = spq_pkg::StServed;
          res.cls     = spq_pkg::class_e'(c);
          res.patient = head.patient;
          res.ticket  = head.ticket;
          res.age     = head.age;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        outcome_q.push_back(predict_outcome(req_op_i, req_class_i,
                                            '{patient: req_patient_i, ticket: req_ticket_i,
                                              age: req_age_i}));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = '{status: spq_pkg::status_e'(rsp_status_i),
                cls: spq_pkg::class_e'(rsp_class_i),
                patient: rsp_patient_i, ticket: rsp_ticket_i, age: rsp_age_i};
        if (outcome_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result transfer with nothing expected: status %0d class %0d",
                     $realtime, got.status, got.cls);
          end
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (got != want) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch expected st %0d cls %0d pat %h tic %h age %h",
                       $realtime, want.status, want.cls, want.patient, want.ticket, want.age);
              $display("%0t:          actual   st %0d cls %0d pat %h tic %h age %h",
                       $realtime, got.status, got.cls, got.patient, got.ticket, got.age);
            end
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= outcome_q.size();
    end
  end

endmodule

/* tb/strict_priority_three_queue_tb.sv */
// ----------------------------------------------------------------------------
// strict_priority_three_queue_tb
// Drives enqueue and serve requests into the three-class queue: a directed
// opening (empty serve, field extremes, bad class, full ring), then random
// fill and drain phases with idle bursts on both channels. The checker
// module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module strict_priority_three_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth    = 16;
  localparam int unsigned RandomItems   = 1200;
  localparam int unsigned CalmItems     = 150;
  localparam int unsigned WatchdogLimit = 1000;
  localparam logic [1:0]  ClassInvalid  = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        calm = 1'b0;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_cycles = 0;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  always #5ns clk_i = ~clk_i;

  strict_priority_three_queue #(
    .QueueDepth(QueueDepth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  strict_priority_three_queue_checker #(
    .QueueDepth(QueueDepth)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_op_i     (req_if.op),
    .req_class_i  (req_if.queue_class),
    .req_patient_i(req_if.patient_id),
    .req_ticket_i (req_if.ticket_id),
    .req_age_i    (req_if.patient_age),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_status_i (rsp_if.status),
    .rsp_class_i  (rsp_if.served_class),
    .rsp_patient_i(rsp_if.served_patient),
    .rsp_ticket_i (rsp_if.served_ticket),
    .rsp_age_i    (rsp_if.served_age),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  task automatic send_item(logic op, logic [1:0] cls, logic [15:0] patient,
                           logic [15:0] ticket, logic [7:0] age);
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.queue_class <= cls;
    req_if.patient_id  <= patient;
    req_if.ticket_id   <= ticket;
    req_if.patient_age <= age;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // idle burst after the transfer
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // result side stalls
  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!calm) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("strict_priority_three_queue test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_left;
    int unsigned mode;
    int unsigned roll;
    logic [1:0]  favored;
    logic [1:0]  cls;
    logic        op;
    phase_left         = 0;
    mode               = 0;
    favored            = spq_pkg::ClassNormal;
    req_if.valid       = 1'b0;
    req_if.op          = spq_pkg::OpEnqueue;
    req_if.queue_class = spq_pkg::ClassNormal;
    req_if.patient_id  = '0;
    req_if.ticket_id   = '0;
    req_if.patient_age = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed opening
    send_item(spq_pkg::OpServe, ClassInvalid, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(spq_pkg::OpEnqueue, spq_pkg::ClassUrgent, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(spq_pkg::OpEnqueue, spq_pkg::ClassPriority, 16'h0000, 16'h0000, 8'h00);
    send_item(spq_pkg::OpEnqueue, ClassInvalid, 16'hA5A5, 16'h5A5A, 8'h81);
    for (int n = 0; n < QueueDepth; n++) begin
      send_item(spq_pkg::OpEnqueue, spq_pkg::ClassNormal, 16'(n * 4099), ~16'(n),
                8'(n * 17));
    end
    send_item(spq_pkg::OpEnqueue, spq_pkg::ClassNormal, 16'h1234, 16'h4321, 8'h42);
    repeat (3) begin
      send_item(spq_pkg::OpServe, spq_pkg::ClassNormal, 16'($urandom), 16'($urandom),
                8'($urandom));
    end

    // random fill and drain phases
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - CalmItems) calm = 1'b1;
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        mode       = $urandom_range(0, 2);
        favored    = 2'($urandom_range(0, 2));
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case (mode)
        0:       op = (roll < 80) ? spq_pkg::OpEnqueue : spq_pkg::OpServe;
        1:       op = (roll < 80) ? spq_pkg::OpServe : spq_pkg::OpEnqueue;
        default: op = (roll < 50) ? spq_pkg::OpEnqueue : spq_pkg::OpServe;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        cls = ClassInvalid;
      end else if (roll < 65) begin
        cls = favored;
      end else begin
        cls = 2'($urandom_range(0, 2));
      end
      send_item(op, cls, 16'($urandom), 16'($urandom), 8'($urandom));
    end
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("strict_priority_three_queue test passed");
    end else begin
      $display("strict_priority_three_queue test failed");
    end
    $finish;
  end

endmodule
